// ===== sv/lru_recency_list_macros.svh =====
// Assertion macros shared by the recency list modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef LRU_RECENCY_LIST_MACROS_SVH
`define LRU_RECENCY_LIST_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define LRU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lru_pkg.sv =====
// Shared types and constants for the recency list block.
// No dependencies.
`timescale 1ns / 1ps

package lru_pkg;

    localparam int FRAME_W     = 4;
    localparam int COUNT_W     = 5;
    localparam int MAX_SLOTS   = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        OP_TOUCH  = 1'b0,
        OP_REMOVE = 1'b1
    } lru_op_t;

    typedef struct packed
    {
        lru_op_t              op;
        logic [FRAME_W-1:0]   id;
        logic                 in_range;
    } lru_cmd_t;

endpackage

// ===== sv/lru_front.sv =====
// Front end: takes input transactions and classifies them into list commands.
// Depends on lru_pkg.
`timescale 1ns / 1ps

module lru_front
#(
    parameter int NUM_FRAMES = 16
)
(
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lru_pkg::S_TDATA_W-1:0] s_tdata,   // action, frame_num
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output lru_pkg::lru_cmd_t             cmd
);
    import lru_pkg::*;

    logic [FRAME_W-1:0] id;

    assign id            = s_tdata[FRAME_W:1];
    assign cmd.op        = s_tdata[0] ? OP_REMOVE : OP_TOUCH;
    assign cmd.id        = id;
    assign cmd.in_range  = (32'(id) < NUM_FRAMES);
    assign cmd_valid     = s_tvalid;
    assign s_tready      = cmd_ready;

endmodule

// ===== sv/lru_cmd_fifo.sv =====
// Short command queue between the front end and the list core.
// Depends on lru_pkg and lru_recency_list_macros.svh.
`timescale 1ns / 1ps
`include "lru_recency_list_macros.svh"

module lru_cmd_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lru_pkg::lru_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output lru_pkg::lru_cmd_t out_cmd
);
    import lru_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lru_cmd_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              push;
    logic              pop;

    assign in_ready  = (cnt_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    `LRU_ASSERT_ALWAYS(a_fifo_bound, cnt_reg <= CW'(QUEUE_DEPTH), "queue count overflow")
    `LRU_ASSERT_NEXT(a_fifo_grow, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue push lost")
    `LRU_ASSERT_NEXT(a_fifo_shrink, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "queue pop lost")

endmodule

// ===== sv/lru_list_core.sv =====
// Back end: a row of compare-and-shift cells holding the recency order, plus
// the report stage and output register. Depends on lru_pkg and the macros header.
`timescale 1ns / 1ps
`include "lru_recency_list_macros.svh"

module lru_list_core
#(
    parameter int NUM_FRAMES = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  lru_pkg::lru_cmd_t             cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // was_present, head_frame, tail_frame, entry_count, list_empty
    output logic [lru_pkg::M_TDATA_W-1:0] m_tdata
);
    import lru_pkg::*;

    localparam int DEPTH = (NUM_FRAMES < MAX_SLOTS) ? NUM_FRAMES : MAX_SLOTS;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [FRAME_W-1:0]   slots_reg  [DEPTH];
    logic [FRAME_W-1:0]   slots_next [DEPTH];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 rpt_valid_reg;
    logic                 rpt_present_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic [DEPTH-1:0]     match;
    logic [DEPTH-1:0]     at_or_after;
    logic [DEPTH-1:0]     at_or_before;
    logic                 hit;
    logic                 do_insert;
    logic                 st1_fire;
    logic                 rpt_move;
    logic [IW-1:0]        tail_idx;
    logic [FRAME_W-1:0]   head_frame;
    logic [FRAME_W-1:0]   tail_frame;
    logic                 list_empty;

    assign rpt_move  = rpt_valid_reg && (!out_valid_reg || m_tready);
    assign cmd_ready = !rpt_valid_reg || rpt_move;
    assign st1_fire  = cmd_valid && cmd_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (CW'(i) < count_reg) && (slots_reg[i] == cmd.id);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            at_or_after[i]  = |(match >> i);
            at_or_before[i] = |(match << (DEPTH - 1 - i));
        end
    end

    assign hit       = |match;
    assign do_insert = (cmd.op == OP_TOUCH) && !hit && cmd.in_range
                       && (count_reg < CW'(DEPTH));

    always_comb
    begin
        slots_next = slots_reg;
        count_next = count_reg;
        unique case (cmd.op)
            OP_TOUCH:
            begin
                if (hit || do_insert)
                begin
                    slots_next[0] = cmd.id;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (!hit || at_or_after[i])
                        begin
                            slots_next[i] = slots_reg[i-1];
                        end
                    end
                end
                if (do_insert)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        if (at_or_before[i])
                        begin
                            slots_next[i] = slots_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign tail_idx   = IW'(count_reg - 1'b1);
    assign list_empty = (count_reg == '0);
    assign head_frame = list_empty ? '0 : slots_reg[0];
    assign tail_frame = list_empty ? '0 : slots_reg[tail_idx];
    assign out_data_next = {1'b0, list_empty, COUNT_W'(count_reg), tail_frame, head_frame,
                            rpt_present_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rpt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st1_fire)
            begin
                count_reg <= count_next;
            end
            if (st1_fire)
            begin
                rpt_valid_reg <= 1'b1;
            end
            else if (rpt_move)
            begin
                rpt_valid_reg <= 1'b0;
            end
            if (rpt_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st1_fire)
        begin
            slots_reg       <= slots_next;
            rpt_present_reg <= hit;
        end
        if (rpt_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `LRU_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "entry count above capacity")
    `LRU_ASSERT_ALWAYS(a_no_duplicate, !cmd_valid || ($countones(match) <= 1), "frame listed more than once")
    `LRU_ASSERT_NEXT(a_remove_shrinks, st1_fire && (cmd.op == OP_REMOVE) && hit,
                     count_reg == $past(count_reg) - 1'b1, "remove did not shrink list")

endmodule

// ===== sv/lru_recency_list.sv =====
// Top level of the recency list: front end, command queue and list core.
// Depends on lru_pkg, lru_front, lru_cmd_fifo and lru_list_core.
`timescale 1ns / 1ps

// Keeps frames in recency order, most recently used at the head. A touch moves a listed
// frame to the head or inserts an unlisted one; a remove takes a listed frame out. Each
// input transaction gives one output transaction with the presence flag, head, tail,
// count and empty flag after the action. Capacity is the smaller of NUM_FRAMES and 16;
// touches of new frames with an id at or above NUM_FRAMES, or while the list is full, and
// removes of absent frames leave the list unchanged. An accepted transaction passes the
// command queue, the cell row with the report register and the output register, which
// offers its result; back-pressure can hold it at each step. The cell row compares and
// shifts all slots combinationally, so the block sustains one transaction per cycle when
// m_tready holds; a two-entry command queue lets input and output stall independently.
module lru_recency_list
#(
    parameter int NUM_FRAMES = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lru_pkg::S_TDATA_W-1:0] s_tdata,   // action, frame_num
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // was_present, head_frame, tail_frame, entry_count, list_empty
    output logic [lru_pkg::M_TDATA_W-1:0] m_tdata
);
    import lru_pkg::*;

    lru_cmd_t front_cmd;
    lru_cmd_t queue_cmd;
    logic     front_valid;
    logic     front_ready;
    logic     queue_valid;
    logic     queue_ready;

    lru_front
    #(
        .NUM_FRAMES (NUM_FRAMES)
    )
    u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    lru_cmd_fifo u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    lru_list_core
    #(
        .NUM_FRAMES (NUM_FRAMES)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== bench/lru_recency_checker.sv =====
// Checker for the recency list: watches both stream channels, predicts each result
// and compares it field by field. Depends on lru_pkg.
`timescale 1ns / 1ps

module lru_recency_checker
#(
    parameter int NUM_FRAMES = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lru_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lru_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            outstanding
);

    import lru_pkg::*;

    localparam int CAPACITY = (NUM_FRAMES < MAX_SLOTS) ? NUM_FRAMES : MAX_SLOTS;

    typedef struct
    {
        logic               was_present;
        logic [FRAME_W-1:0] head_frame;
        logic [FRAME_W-1:0] tail_frame;
        logic [COUNT_W-1:0] entry_count;
        logic               list_empty;
    } list_status_t;

    logic [FRAME_W-1:0] order_slots [MAX_SLOTS];
    int                 listed_count;
    list_status_t       status_q [$];
    int                 mismatches;

    assign fail_count = mismatches;

    // Applies one action to the predicted order and returns the status after it.
    function automatic list_status_t apply_action(input lru_op_t op, input logic [FRAME_W-1:0] id);
        list_status_t st;
        int pos;
        int i;
        pos = -1;
        for (i = 0; i < listed_count; i++)
        begin
            if (pos < 0 && order_slots[i] == id)
            begin
                pos = i;
            end
        end
        if (op == OP_TOUCH)
        begin
            if (pos >= 0)
            begin
                for (i = pos; i > 0; i--)
                begin
                    order_slots[i] = order_slots[i-1];
                end
                order_slots[0] = id;
            end
            else if (int'(id) < NUM_FRAMES && listed_count < CAPACITY)
            begin
                for (i = listed_count; i > 0; i--)
                begin
                    order_slots[i] = order_slots[i-1];
                end
                order_slots[0] = id;
                listed_count++;
            end
        end
        else if (pos >= 0)
        begin
            for (i = pos; i + 1 < listed_count; i++)
            begin
                order_slots[i] = order_slots[i+1];
            end
            listed_count--;
        end
        st.was_present = (pos >= 0);
        st.entry_count = COUNT_W'(listed_count);
        st.list_empty  = (listed_count == 0);
        st.head_frame  = (listed_count > 0) ? order_slots[0] : '0;
        st.tail_frame  = (listed_count > 0) ? order_slots[listed_count-1] : '0;
        return st;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_status_t exp_st;
        if (!rst_n)
        begin
            listed_count = 0;
            status_q.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                status_q.push_back(apply_action(lru_op_t'(s_tdata[0]), s_tdata[FRAME_W:1]));
            end
            if (m_tvalid && m_tready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("Output transaction with no expected result pending.");
                    mismatches++;
                end
                else
                begin
                    exp_st = status_q.pop_front();
                    compare_field("was_present", 32'(exp_st.was_present), 32'(m_tdata[0]));
                    compare_field("head_frame", 32'(exp_st.head_frame), 32'(m_tdata[4:1]));
                    compare_field("tail_frame", 32'(exp_st.tail_frame), 32'(m_tdata[8:5]));
                    compare_field("entry_count", 32'(exp_st.entry_count), 32'(m_tdata[13:9]));
                    compare_field("list_empty", 32'(exp_st.list_empty), 32'(m_tdata[14]));
                end
            end
            outstanding <= status_q.size();
        end
    end

endmodule

// ===== bench/lru_recency_list_tb.sv =====
// Testbench top for the recency list: drives directed and random touch and remove
// transactions with random idling. Depends on lru_pkg, lru_recency_list and the checker.
`timescale 1ns / 1ps

module lru_recency_list_tb;

    import lru_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 500;
    localparam int DRAIN_CYCLES = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   outstanding;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   cycle_count;

    lru_recency_list #(.NUM_FRAMES(16)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lru_recency_checker #(.NUM_FRAMES(16)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_action(input lru_op_t op, input logic [FRAME_W-1:0] id);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-FRAME_W-1){1'b0}}, id, op};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        int n;
        int touch_pct;
        touch_pct = 70;
        for (n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: touch_pct = 30;
                    1: touch_pct = 70;
                    default: touch_pct = 92;
                endcase
            end
            send_action(($urandom_range(0, 99) < touch_pct) ? OP_TOUCH : OP_REMOVE,
                        FRAME_W'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        int f;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cycle_count   = 0;
        send_idle_pct = 18;
        recv_idle_pct = 59;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, move to head, tail removal, absent removal, back to empty.
        send_action(OP_REMOVE, 4'd0);
        send_action(OP_TOUCH, 4'd0);
        send_action(OP_TOUCH, 4'd15);
        send_action(OP_TOUCH, 4'd15);
        send_action(OP_TOUCH, 4'd0);
        send_action(OP_REMOVE, 4'd15);
        send_action(OP_REMOVE, 4'd15);
        send_action(OP_REMOVE, 4'd0);
        // Fill to capacity, then move and remove in the middle of a full list.
        for (f = 0; f < 16; f++)
        begin
            send_action(OP_TOUCH, FRAME_W'(f));
        end
        send_action(OP_TOUCH, 4'd5);
        send_action(OP_REMOVE, 4'd9);

        send_random(PHASE_ITEMS - 26);
        send_idle_pct = 59;
        recv_idle_pct = 18;
        send_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lru_pkg.sv
sv/lru_front.sv
sv/lru_cmd_fifo.sv
sv/lru_list_core.sv
sv/lru_recency_list.sv
bench/lru_recency_checker.sv
bench/lru_recency_list_tb.sv
